[rtl/core/store_and_forward_frame_mailbox_macros.svh]
// assertion macros for the frame mailbox
`ifndef STORE_AND_FORWARD_FRAME_MAILBOX_MACROS_SVH
`define STORE_AND_FORWARD_FRAME_MAILBOX_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define SFFM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sffm assertion failed");
// condition implies consequence on the next edge
`define SFFM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("sffm assertion failed");
`else
`define SFFM_ASSERT(label, clk, rst_n, prop)
`define SFFM_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

[rtl/core/sffm_pkg.sv]
// shared types and constants of the frame mailbox
package sffm_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 16;
	localparam int unsigned MAX_DELIVER    = 16;
	localparam int unsigned ADDR_W         = 16;
	localparam int unsigned LEN_W          = 12;
	localparam int unsigned KIND_W         = 3;
	localparam int unsigned SLOT_W         = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_STORED  = 3'd0,
		KIND_DUP     = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_IGNORED = 3'd3,
		KIND_DELIVER = 3'd4,
		KIND_DONE    = 3'd5
	} kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] src;
		logic [LEN_W-1:0]  len;
	} hdr_t;

	localparam int unsigned ENTRY_W = $bits(hdr_t);

endpackage

[rtl/core/sffm_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module sffm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/store_and_forward_frame_mailbox.sv]
// top level of the store-and-forward frame mailbox
`include "store_and_forward_frame_mailbox_macros.svh"

// frame mailbox: keeps relayed frame headers in SLOT_COUNT slots of one ram and
// hands them to the addressed node on request. a transaction is taken when start
// is high and busy is low. a relayed non-request frame or a request aimed at
// own_address walks the whole ram, one slot read per cycle, so busy stays high
// through the scan and the closing step; the scan goes through the single read
// port. any other frame is answered as ignored without a scan, busy stays low.
// results appear on the out_ ports for exactly one cycle with strobe high; the
// receiver cannot stall them, so it must take every strobe. a request gives one
// delivered result per matching slot (at most 16, lowest slot first, out_last
// low) and then a done result. slots are empty after reset through per-slot
// valid bits, so no clearing pass is needed. own_address is to be written by the
// user through cfg_wr_en/cfg_wr_data while the block is idle; it does not enforce this.
module store_and_forward_frame_mailbox
	import sffm_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  logic              start,
	output logic              busy,
	input  logic [ADDR_W-1:0] in_dest,
	input  logic [ADDR_W-1:0] in_src,
	input  logic [LEN_W-1:0]  in_length,
	input  logic              is_relayed,
	input  logic              is_request,
	output logic              strobe,
	output logic [KIND_W-1:0] out_kind,
	output logic [ADDR_W-1:0] out_dest,
	output logic [ADDR_W-1:0] out_src,
	output logic [LEN_W-1:0]  out_length,
	output logic [SLOT_W-1:0] out_slot,
	output logic              out_last
);

	// slot index and scan counter widths
	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int unsigned DLV_W = $clog2(MAX_DELIVER + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// store mode (relayed frame) versus request mode
	logic              store_mode_q;
	hdr_t              hdr_q;
	logic [ADDR_W-1:0] own_addr_q;

	// read issue counter and first pipeline stage of the scan
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	// scan results
	logic              dup_q;
	logic              empty_found_q;
	logic [IDX_W-1:0]  empty_idx_q;
	logic [DLV_W-1:0]  dlv_cnt_q;

	// per-slot valid bits: an unwritten slot reads as all zero
	logic [SLOT_COUNT-1:0] valid_q;

	// registered result
	logic              strobe_q;
	kind_t             kind_q;
	hdr_t              res_hdr_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_last_q;

	// ram ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	hdr_t              ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	hdr_t              entry;
	logic              accept;
	logic              is_store_op;
	logic              is_req_op;
	logic              dup_hit;
	logic              empty_hit;
	logic              dlv_hit;
	logic              scan_end;

	// low four bits of a slot index, zero extended for small mailboxes
	function automatic logic [SLOT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	sffm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign is_store_op = is_relayed && !is_request;
	assign is_req_op   = is_request && (in_dest == own_addr_q);

	// slot data of the read issued last cycle
	assign entry = valid_q[idx_s1] ? hdr_t'(ram_rdata) : hdr_t'('0);

	assign dup_hit   = (entry.dest == hdr_q.dest) && (entry.src == hdr_q.src)
	                && (entry.len == hdr_q.len);
	assign empty_hit = (entry.dest == '0) && (entry.src == '0);
	// requester address is the source of the request frame
	assign dlv_hit   = (entry.dest == hdr_q.src) && (dlv_cnt_q < DLV_W'(MAX_DELIVER));
	assign scan_end  = rd_vld_s1 && (idx_s1 == LAST_IDX);

	// one read a cycle while slots remain to be issued
	assign ram_re    = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(SLOT_COUNT));
	assign ram_raddr = rd_cnt_q[IDX_W-1:0];

	// write port: clear on delivery during the scan, fill on store at the end
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = hdr_q;
		if (state_q == ST_SCAN && rd_vld_s1 && !store_mode_q && dlv_hit) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			// a cleared slot keeps its length
			ram_wdata = '{dest: '0, src: '0, len: entry.len};
		end else if (state_q == ST_FINISH && store_mode_q && !dup_q && empty_found_q) begin
			ram_we    = 1'b1;
			ram_waddr = empty_idx_q;
			ram_wdata = hdr_q;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
		end else if (cfg_wr_en) begin
			own_addr_q <= cfg_wr_data;
		end
	end

	// sequencer, scan pipeline and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			store_mode_q  <= 1'b0;
			hdr_q         <= '0;
			rd_cnt_q      <= '0;
			rd_vld_s1     <= 1'b0;
			idx_s1        <= '0;
			dup_q         <= 1'b0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			dlv_cnt_q     <= '0;
			valid_q       <= '0;
			strobe_q      <= 1'b0;
			kind_q        <= KIND_IGNORED;
			res_hdr_q     <= '0;
			res_slot_q    <= '0;
			res_last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				idx_s1   <= ram_raddr;
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hdr_q         <= '{dest: in_dest, src: in_src, len: in_length};
						store_mode_q  <= is_store_op;
						rd_cnt_q      <= '0;
						dup_q         <= 1'b0;
						empty_found_q <= 1'b0;
						empty_idx_q   <= '0;
						dlv_cnt_q     <= '0;
						if (is_store_op || is_req_op) begin
							state_q <= ST_SCAN;
						end else begin
							// anything else is answered at once
							strobe_q   <= 1'b1;
							kind_q     <= KIND_IGNORED;
							res_hdr_q  <= '{dest: in_dest, src: in_src, len: in_length};
							res_slot_q <= '0;
							res_last_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (store_mode_q) begin
							if (dup_hit) begin
								dup_q <= 1'b1;
							end
							if (empty_hit && !empty_found_q) begin
								empty_found_q <= 1'b1;
								empty_idx_q   <= idx_s1;
							end
						end else if (dlv_hit) begin
							strobe_q   <= 1'b1;
							kind_q     <= KIND_DELIVER;
							res_hdr_q  <= entry;
							res_slot_q <= slot_code(idx_s1);
							res_last_q <= 1'b0;
							dlv_cnt_q  <= dlv_cnt_q + DLV_W'(1);
						end
					end
					if (scan_end) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					strobe_q   <= 1'b1;
					res_last_q <= 1'b1;
					res_hdr_q  <= hdr_q;
					res_slot_q <= '0;
					if (!store_mode_q) begin
						kind_q    <= KIND_DONE;
						res_hdr_q <= '0;
					end else if (dup_q) begin
						kind_q <= KIND_DUP;
					end else if (empty_found_q) begin
						kind_q     <= KIND_STORED;
						res_slot_q <= slot_code(empty_idx_q);
					end else begin
						kind_q <= KIND_FULL;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign out_kind   = kind_q;
	assign out_dest   = res_hdr_q.dest;
	assign out_src    = res_hdr_q.src;
	assign out_length = res_hdr_q.len;
	assign out_slot   = res_slot_q;
	assign out_last   = res_last_q;

	// a delivered frame always belongs to the requester being served
	`SFFM_ASSERT(a_dlv_dest, clk, arst_n,
		!(strobe && out_kind == KIND_DELIVER) || (out_dest == hdr_q.src && busy))
	// never more deliveries than the per-request limit
	`SFFM_ASSERT(a_dlv_limit, clk, arst_n, dlv_cnt_q <= DLV_W'(MAX_DELIVER))
	// the ram is only written while a transaction is in work
	`SFFM_ASSERT(a_we_busy, clk, arst_n, !ram_we || busy)
	// the closing step always gives a final result and frees the block
	`SFFM_ASSERT_NEXT(a_finish, clk, arst_n, state_q == ST_FINISH,
		strobe && out_last && !busy)

endmodule

[verif/tb_store_and_forward_frame_mailbox.sv]
// testbench for the store-and-forward frame mailbox: directed and random frames
module tb_store_and_forward_frame_mailbox;
	import sffm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOT_COUNT  = SLOT_COUNT_DEF;
	// generous bound: every item with its longest sender gap, a full scan and 17 results,
	// several times over, plus the settling pauses between phases
	localparam int unsigned CYCLE_LIMIT = 400000;

	// one result as the mailbox should report it
	typedef struct {
		kind_t             kind;
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] src;
		logic [LEN_W-1:0]  len;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} mail_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;
	logic              start;
	logic              busy;
	logic [ADDR_W-1:0] in_dest;
	logic [ADDR_W-1:0] in_src;
	logic [LEN_W-1:0]  in_length;
	logic              is_relayed;
	logic              is_request;
	logic              strobe;
	logic [KIND_W-1:0] out_kind;
	logic [ADDR_W-1:0] out_dest;
	logic [ADDR_W-1:0] out_src;
	logic [LEN_W-1:0]  out_length;
	logic [SLOT_W-1:0] out_slot;
	logic              out_last;

	// predicted mailbox contents and the node address as last written
	logic [ADDR_W-1:0] box_dest [SLOT_COUNT] = '{default: '0};
	logic [ADDR_W-1:0] box_src  [SLOT_COUNT] = '{default: '0};
	logic [LEN_W-1:0]  box_len  [SLOT_COUNT] = '{default: '0};
	logic [ADDR_W-1:0] node_addr = '0;

	// results still owed by the mailbox, oldest first
	mail_result_t pending_results [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int          sender_idle_pct = 0;

	// small pools of addresses and lengths so that random frames collide often
	logic [ADDR_W-1:0] addr_pool [4];
	logic [LEN_W-1:0]  len_pool [3];

	store_and_forward_frame_mailbox #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.busy       (busy),
		.in_dest    (in_dest),
		.in_src     (in_src),
		.in_length  (in_length),
		.is_relayed (is_relayed),
		.is_request (is_request),
		.strobe     (strobe),
		.out_kind   (out_kind),
		.out_dest   (out_dest),
		.out_src    (out_src),
		.out_length (out_length),
		.out_slot   (out_slot),
		.out_last   (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor and checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic void queue_result(input kind_t k, input logic [ADDR_W-1:0] d,
		input logic [ADDR_W-1:0] s, input logic [LEN_W-1:0] len, input int slot,
		input logic last);
		mail_result_t r;
		r.kind = k;
		r.dest = d;
		r.src  = s;
		r.len  = len;
		r.slot = SLOT_W'(slot);
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// works out what one accepted frame does to the mailbox and what it reports
	function automatic void predict_frame(input logic [ADDR_W-1:0] d,
		input logic [ADDR_W-1:0] s, input logic [LEN_W-1:0] len, input logic rel,
		input logic req);
		int hit;
		int free_slot;
		int sent;
		hit = -1;
		free_slot = -1;
		sent = 0;
		if (rel && !req) begin
			// duplicate check runs over every slot, empty ones included
			for (int i = 0; i < SLOT_COUNT; i++)
				if (hit < 0 && box_dest[i] == d && box_src[i] == s && box_len[i] == len)
					hit = i;
			// lowest empty slot: destination and source both zero
			for (int i = SLOT_COUNT - 1; i >= 0; i--)
				if (box_dest[i] == '0 && box_src[i] == '0)
					free_slot = i;
			if (hit >= 0) begin
				queue_result(KIND_DUP, d, s, len, 0, 1'b1);
			end else if (free_slot >= 0) begin
				box_dest[free_slot] = d;
				box_src[free_slot]  = s;
				box_len[free_slot]  = len;
				queue_result(KIND_STORED, d, s, len, free_slot, 1'b1);
			end else begin
				queue_result(KIND_FULL, d, s, len, 0, 1'b1);
			end
		end else if (req && d == node_addr) begin
			// deliver lowest slot first; clearing leaves the length behind
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (sent < MAX_DELIVER && box_dest[i] == s) begin
					queue_result(KIND_DELIVER, box_dest[i], box_src[i], box_len[i], i, 1'b0);
					box_dest[i] = '0;
					box_src[i]  = '0;
					sent++;
				end
			end
			queue_result(KIND_DONE, '0, '0, '0, 0, 1'b1);
		end else begin
			queue_result(KIND_IGNORED, d, s, len, 0, 1'b1);
		end
	endfunction

	task automatic check_result();
		mail_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing owed: kind %0d dest %h src %h",
				out_kind, out_dest, out_src));
			return;
		end
		want = pending_results.pop_front();
		if (out_kind !== want.kind)
			report_mismatch($sformatf("kind %0d, wanted %s", out_kind, want.kind.name()));
		if (out_dest !== want.dest)
			report_mismatch($sformatf("dest %h, wanted %h", out_dest, want.dest));
		if (out_src !== want.src)
			report_mismatch($sformatf("src %h, wanted %h", out_src, want.src));
		if (out_length !== want.len)
			report_mismatch($sformatf("length %0d, wanted %0d", out_length, want.len));
		if (out_slot !== want.slot)
			report_mismatch($sformatf("slot %0d, wanted %0d", out_slot, want.slot));
		if (out_last !== want.last)
			report_mismatch($sformatf("last %b, wanted %b", out_last, want.last));
	endtask

	// everything is sampled as it stood just before the edge; frame acceptance and
	// register writes update the predictor ahead of the result check, so even a
	// same-cycle answer finds its expectation waiting; a frame taken at the same
	// edge as a write still sees the old node address
	always @(posedge clk) begin
		if (arst_n) begin
			if (start === 1'b1 && busy === 1'b0)
				predict_frame(in_dest, in_src, in_length, is_relayed, is_request);
			if (cfg_wr_en === 1'b1)
				node_addr = cfg_wr_data;
			if (strobe !== 1'b0)
				check_result();
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one frame transaction; start is left high on return so that a back-to-back
	// frame follows without a dip, and the caller lowers it in the same step
	task automatic send_frame(input logic [ADDR_W-1:0] d, input logic [ADDR_W-1:0] s,
		input logic [LEN_W-1:0] len, input logic rel, input logic req);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		in_dest    <= d;
		in_src     <= s;
		in_length  <= len;
		is_relayed <= rel;
		is_request <= req;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// sender stops and waits for every owed result; it lets the predictor see the
	// transaction taken at the last edge before it looks at the queue
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// drained, then a wait longer than a full scan, so the block is idle for a write
	task automatic settle_mailbox();
		wait_drained();
		repeat (SLOT_COUNT + 4) @(posedge clk);
	endtask

	task automatic write_own_address(input logic [ADDR_W-1:0] addr);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] pool_addr();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return addr_pool[$urandom_range(3)];
		if (roll < 85)
			return '0;
		if (roll < 90)
			return '1;
		return ADDR_W'($urandom_range(65535));
	endfunction

	function automatic logic [LEN_W-1:0] pool_len();
		if ($urandom_range(99) < 60)
			return len_pool[$urandom_range(2)];
		return LEN_W'($urandom_range(2304));
	endfunction

	// mostly relayed frames and requests from known nodes, some resends of held
	// headers, the rest frames the mailbox should pass over
	task automatic send_random_frame(input int req_pct);
		int                pick;
		int                k;
		logic [ADDR_W-1:0] d;
		logic [ADDR_W-1:0] s;
		logic [LEN_W-1:0]  len;
		logic              rel;
		logic              req;
		pick = $urandom_range(99);
		d    = pool_addr();
		s    = pool_addr();
		len  = pool_len();
		rel  = 1'b1;
		req  = 1'b0;
		if (pick < req_pct) begin
			// request, nearly always aimed at this node
			req = 1'b1;
			rel = 1'($urandom_range(1));
			if ($urandom_range(9) != 0)
				d = node_addr;
		end else if (pick < req_pct + 12) begin
			// resend of whatever a slot holds, empty slots included
			k   = $urandom_range(SLOT_COUNT - 1);
			d   = box_dest[k];
			s   = box_src[k];
			len = box_len[k];
		end else if (pick < req_pct + 22) begin
			// not relayed: ignored unless it happens to be a request for this node
			rel = 1'b0;
			req = 1'($urandom_range(1));
			d   = ADDR_W'($urandom_range(65535));
		end
		send_frame(d, s, len, rel, req);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// straight after reset: own address 0, every slot empty with length 0
	task automatic test_requester_zero();
		sender_idle_pct = 0;
		// zero header, zero length matches an empty slot: duplicate
		send_frame('0, '0, '0, 1'b1, 1'b0);
		// zero header with a new length is still stored, slot stays empty in effect
		send_frame('0, '0, 12'd5, 1'b1, 1'b0);
		// requester address zero picks up every empty slot
		send_frame('0, '0, '0, 1'b0, 1'b1);
	endtask

	// fill all sixteen slots, then a resend and an overflow
	task automatic test_fill_and_full();
		logic [ADDR_W-1:0] d;
		logic [LEN_W-1:0]  len;
		settle_mailbox();
		write_own_address('1);
		sender_idle_pct = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			d   = i[0] ? 16'hFFFF : (16'h8000 ^ ADDR_W'(i));
			len = (i == SLOT_COUNT - 1) ? 12'd2304 : LEN_W'(i * 153);
			send_frame(d, 16'hFFFF - ADDR_W'(i), len, 1'b1, 1'b0);
		end
		// duplicate of slot three is checked before fullness
		send_frame(16'hFFFF, 16'hFFFC, 12'd459, 1'b1, 1'b0);
		send_frame(16'h5555, 16'hAAAA, 12'd100, 1'b1, 1'b0);
	endtask

	// delivery to this node, then the cases that must be passed over
	task automatic test_delivery_and_ignored();
		sender_idle_pct = 0;
		// odd slots hold destination ffff: eight deliveries and done
		send_frame(16'hFFFF, 16'hFFFF, 12'd7, 1'b0, 1'b1);
		// cleared slot keeps its length, so a zero header of that length is a duplicate
		send_frame('0, '0, 12'd153, 1'b1, 1'b0);
		// request for another node
		send_frame(16'h1234, 16'h8000, 12'd0, 1'b0, 1'b1);
		// neither relayed nor a request
		send_frame(16'h8000, 16'hFFFF, 12'd0, 1'b0, 1'b0);
		// relayed request with no matching slot: done only
		send_frame(16'hFFFF, 16'h4321, 12'hFFF & 12'd2047, 1'b1, 1'b1);
	endtask

	// random traffic under one node address and one sender idle rate
	task automatic test_random_traffic(input int idle_pct, input logic [ADDR_W-1:0] own,
		input int count);
		int req_pct;
		settle_mailbox();
		write_own_address(own);
		sender_idle_pct = idle_pct;
		req_pct = 20;
		addr_pool[0] = own;
		for (int i = 1; i < 4; i++)
			addr_pool[i] = ADDR_W'($urandom_range(65535));
		for (int i = 0; i < 3; i++)
			len_pool[i] = LEN_W'($urandom_range(2304));
		for (int n = 0; n < count; n++) begin
			// change the request mix now and then so the store both fills and empties
			if (n % 40 == 0)
				case ($urandom_range(2))
					0: req_pct = 5;
					1: req_pct = 20;
					default: req_pct = 40;
				endcase
			// sender holds off until nothing is owed
			if (n % 50 == 49)
				wait_drained();
			send_random_frame(req_pct);
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		start       <= 1'b0;
		in_dest     <= '0;
		in_src      <= '0;
		in_length   <= '0;
		is_relayed  <= 1'b0;
		is_request  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_requester_zero();
		test_fill_and_full();
		test_delivery_and_ignored();
		// sender idles rarely at first, then often, then never
		test_random_traffic(12, ADDR_W'($urandom_range(65535)), 150);
		test_random_traffic(57, '0, 150);
		test_random_traffic(0, '1, 150);

		// let any stray result show up before the verdict
		wait_drained();
		repeat (SLOT_COUNT + 4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
